>>> rtl/rmnl_pkg.sv
// Shared types and constants for the range map nearest lookup block.
// No dependencies.
package rmnl_pkg;

    localparam int TableDepth = 64;
    localparam int IdxW = $clog2(TableDepth);
    localparam int CntW = $clog2(TableDepth + 1);
    localparam int LineWeight = 1000;
    localparam int WeightW = $clog2(LineWeight + 1);
    localparam int DistW = 20 + WeightW + 1;

    typedef enum logic [2:0] {
        MODE_INSERT = 3'd0,
        MODE_CODE   = 3'd1,
        MODE_SRC    = 3'd2,
        MODE_LINE   = 3'd3,
        MODE_CLEAR  = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NEAREST = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        logic [23:0] code_start;
        logic [23:0] code_len;
        logic [23:0] src_start;
        logic [23:0] src_len;
        logic [19:0] line_no;
        logic [15:0] col_no;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic            load_key;   // latch request
        logic            wr;         // write entry at wr_idx
        logic [IdxW-1:0] wr_idx;
        logic            rd;         // read slot rd_idx
        logic [IdxW-1:0] rd_idx;
        logic            first;      // data valid for slot 0
        logic            eval;       // rd data valid this cycle
        logic            fetch;      // read best slot
        logic            out_load;   // latch result from read data
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       exact;
    } dp_stat_t;

endpackage

>>> rtl/rmnl_ctrl.sv
// Sequencer for the lookup block: accepts a request, drives the table scan,
// and holds the result handshake. Depends on rmnl_pkg.
module rmnl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        mode,
    output logic              out_valid,
    input  logic              out_stall,
    output rmnl_pkg::dp_cmd_t cmd,
    input  rmnl_pkg::dp_stat_t stat,
    output logic [1:0]        status
);
    import rmnl_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_FETCH, S_OUT} state_t;

    state_t state_reg, state_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [CntW-1:0] scan_reg, scan_next;
    logic [1:0] status_reg, status_next;
    logic out_valid_reg, out_valid_next;
    logic data_reg, data_next;   // read data from previous cycle is valid
    logic first_reg, first_next;

    logic accept;
    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;
    assign accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign status = status_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        scan_next = scan_reg;
        status_next = status_reg;
        out_valid_next = out_valid_reg;
        data_next = 1'b0;
        first_next = 1'b0;
        cmd = '0;
        cmd.wr_idx = count_reg[IdxW-1:0];
        cmd.rd_idx = scan_reg[IdxW-1:0];
        cmd.eval = data_reg;
        cmd.first = first_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_key = 1'b1;
                    status_next = ST_OK;
                    case (mode)
                        MODE_INSERT:
                        begin
                            if (count_reg == CntW'(TableDepth))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                cmd.wr = 1'b1;
                                count_next = count_reg + CntW'(1);
                            end
                            out_valid_next = 1'b1;
                        end
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                            out_valid_next = 1'b1;
                        end
                        MODE_CODE, MODE_SRC, MODE_LINE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                scan_next = '0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.rd = 1'b1;
                data_next = 1'b1;
                first_next = (scan_reg == '0);
                scan_next = scan_reg + CntW'(1);
                if (scan_reg + CntW'(1) == count_reg)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                // last compare happens this cycle
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                cmd.fetch = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.out_load = 1'b1;
                if (stat.mode != MODE_LINE && !stat.exact)
                begin
                    status_next = ST_NEAREST;
                end
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            scan_reg <= '0;
            status_reg <= ST_OK;
            out_valid_reg <= 1'b0;
            data_reg <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            scan_reg <= scan_next;
            status_reg <= status_next;
            out_valid_reg <= out_valid_next;
            data_reg <= data_next;
            first_reg <= first_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(TableDepth))
        else $error("entry count beyond depth");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input taken during scan");
    a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |=> out_valid_reg)
        else $error("scan finished without result");

endmodule

>>> rtl/rmnl_datapath.sv
// Table memory, scan compare logic and result registers.
// Depends on rmnl_pkg.
module rmnl_datapath (
    input  logic               clk,
    input  logic [2:0]         mode,
    input  logic [23:0]        code_start,
    input  logic [23:0]        code_len,
    input  logic [23:0]        src_start,
    input  logic [23:0]        src_len,
    input  logic [19:0]        line_no,
    input  logic [15:0]        col_no,
    input  rmnl_pkg::dp_cmd_t  cmd,
    output rmnl_pkg::dp_stat_t stat,
    output logic [23:0]        hit_code_start,
    output logic [23:0]        hit_code_len,
    output logic [23:0]        hit_src_start,
    output logic [23:0]        hit_src_len,
    output logic [19:0]        hit_line,
    output logic [15:0]        hit_col
);
    import rmnl_pkg::*;

    entry_t mem [TableDepth];
    entry_t rd_reg;
    entry_t out_reg;

    logic [2:0]  mode_reg;
    logic [23:0] key_reg;
    logic [19:0] kline_reg;
    logic [15:0] kcol_reg;
    logic [IdxW-1:0] idx_reg;   // slot of data in rd_reg

    // offset and line/column search trackers
    logic            hit_v_reg;
    logic [23:0]     hit_s_reg;
    logic [IdxW-1:0] hit_i_reg;
    logic            blw_v_reg;
    logic [23:0]     blw_s_reg;
    logic [IdxW-1:0] blw_i_reg;
    logic [23:0]     low_s_reg;
    logic [IdxW-1:0] low_i_reg;
    logic [DistW-1:0] best_d_reg;
    logic [IdxW-1:0]  best_i_reg;

    logic [IdxW-1:0] fetch_idx;

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[cmd.wr_idx] <= {code_start, code_len, src_start, src_len, line_no, col_no};
        end
        if (cmd.rd)
        begin
            rd_reg <= mem[cmd.rd_idx];
            idx_reg <= cmd.rd_idx;
        end
        else if (cmd.fetch)
        begin
            rd_reg <= mem[fetch_idx];
        end
    end

    always_comb
    begin
        if (mode_reg == MODE_LINE)
            fetch_idx = best_i_reg;
        else if (hit_v_reg)
            fetch_idx = hit_i_reg;
        else if (blw_v_reg)
            fetch_idx = blw_i_reg;
        else
            fetch_idx = low_i_reg;
    end

    logic [23:0] s_cur, l_cur;
    logic [24:0] e_cur;
    logic        le, cont;
    logic [19:0] dl;
    logic [15:0] dc;
    logic [DistW-1:0] d_cur;
    always_comb
    begin
        s_cur = (mode_reg == MODE_SRC) ? rd_reg.src_start : rd_reg.code_start;
        l_cur = (mode_reg == MODE_SRC) ? rd_reg.src_len : rd_reg.code_len;
        e_cur = {1'b0, s_cur} + {1'b0, l_cur};
        le = s_cur <= key_reg;
        cont = le && ({1'b0, key_reg} < e_cur);
        dl = (rd_reg.line_no >= kline_reg) ? rd_reg.line_no - kline_reg
                                           : kline_reg - rd_reg.line_no;
        dc = (rd_reg.col_no >= kcol_reg) ? rd_reg.col_no - kcol_reg
                                         : kcol_reg - rd_reg.col_no;
        d_cur = DistW'(dl) * DistW'(LineWeight)
              + ((dl == '0) ? DistW'(dc) : DistW'(0));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
        begin
            mode_reg <= mode;
            key_reg <= (mode == MODE_SRC) ? src_start : code_start;
            kline_reg <= line_no;
            kcol_reg <= col_no;
        end
        if (cmd.eval)
        begin
            if (cmd.first || (cont && (!hit_v_reg || s_cur < hit_s_reg)))
            begin
                hit_v_reg <= cont;
                hit_s_reg <= s_cur;
                hit_i_reg <= idx_reg;
            end
            if (cmd.first || (le && (!blw_v_reg || s_cur > blw_s_reg)))
            begin
                blw_v_reg <= le;
                blw_s_reg <= s_cur;
                blw_i_reg <= idx_reg;
            end
            if (cmd.first || s_cur < low_s_reg)
            begin
                low_s_reg <= s_cur;
                low_i_reg <= idx_reg;
            end
            if (cmd.first || d_cur < best_d_reg)
            begin
                best_d_reg <= d_cur;
                best_i_reg <= idx_reg;
            end
        end
        if (cmd.load_key)
            out_reg <= '0;
        else if (cmd.out_load)
            out_reg <= rd_reg;
    end

    assign stat.mode = mode_reg;
    assign stat.exact = hit_v_reg;
    assign hit_code_start = out_reg.code_start;
    assign hit_code_len = out_reg.code_len;
    assign hit_src_start = out_reg.src_start;
    assign hit_src_len = out_reg.src_len;
    assign hit_line = out_reg.line_no;
    assign hit_col = out_reg.col_no;

endmodule

>>> rtl/range_map_nearest_lookup.sv
// Range map nearest lookup: 64-entry mapping table with offset and
// line/column search. Insert, clear and empty-table requests give their result
// in the cycle after they are accepted; a lookup does one table read per entry
// through a single memory read port, then fetches the best slot. One request at a
// time: the next input transfer comes no sooner than the cycle after the result transfer.
// Reset empties the table (entry count to zero), drops any pending result, keeps contents.
module range_map_nearest_lookup (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [23:0] code_start,
    input  logic [23:0] code_len,
    input  logic [23:0] src_start,
    input  logic [23:0] src_len,
    input  logic [19:0] line_no,
    input  logic [15:0] col_no,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [23:0] hit_code_start,
    output logic [23:0] hit_code_len,
    output logic [23:0] hit_src_start,
    output logic [23:0] hit_src_len,
    output logic [19:0] hit_line,
    output logic [15:0] hit_col
);
    import rmnl_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rmnl_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .out_valid(out_valid), .out_stall(out_stall),
        .cmd(cmd), .stat(stat), .status(status)
    );

    rmnl_datapath u_dp (
        .clk(clk), .mode(mode), .code_start(code_start), .code_len(code_len),
        .src_start(src_start), .src_len(src_len), .line_no(line_no),
        .col_no(col_no), .cmd(cmd), .stat(stat),
        .hit_code_start(hit_code_start), .hit_code_len(hit_code_len),
        .hit_src_start(hit_src_start), .hit_src_len(hit_src_len),
        .hit_line(hit_line), .hit_col(hit_col)
    );

endmodule
